### design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CRSF_ASSERT(label, ante, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (conseq)) \
		else $error(msg);

// next-cycle implication
`define CRSF_ASSERT_NEXT(label, ante, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (conseq)) \
		else $error(msg);

`endif

### design/crsf_pkg.sv
// Shared types, constants and CRC step function for the CRSF deframer.
package crsf_pkg;

	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DROPPED_TYPE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_TYPE_START = 2'd2;

	localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST    = 8'd238;
	localparam logic [BYTE_W-1:0] DROPPED_TYPE_RST   = 8'd22;
	localparam logic [BYTE_W-1:0] EXT_TYPE_START_RST = 8'd40;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] own_address;
		logic [BYTE_W-1:0] dropped_type;
		logic [BYTE_W-1:0] ext_type_start;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_offset;
		logic [BYTE_W-1:0] frame_kind;
		logic [BYTE_W-1:0] lead_address;
		logic [BYTE_W-1:0] dest_address;
		logic [BYTE_W-1:0] source_address;
		logic              crc_match;
		logic              readable;
		logic              last;
	} res_t;

	// CRC-8, poly 0xD5, MSB first, one byte
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] c,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = c ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			v = v[BYTE_W-1] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

### design/crsf_byte_if.sv
// Valid/ready channel carrying one received link byte.
interface crsf_byte_if import crsf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

### design/crsf_result_if.sv
// Valid/ready channel carrying one deframer result item.
interface crsf_result_if import crsf_pkg::*;;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] data_byte;
	logic [BYTE_W-1:0] byte_offset;
	logic [BYTE_W-1:0] frame_kind;
	logic [BYTE_W-1:0] lead_address;
	logic [BYTE_W-1:0] dest_address;
	logic [BYTE_W-1:0] source_address;
	logic              crc_match;
	logic              readable;
	logic              last;

	modport source(output valid, output kind, output data_byte, output byte_offset,
		output frame_kind, output lead_address, output dest_address,
		output source_address, output crc_match, output readable, output last,
		input ready);
	modport sink(input valid, input kind, input data_byte, input byte_offset,
		input frame_kind, input lead_address, input dest_address,
		input source_address, input crc_match, input readable, input last,
		output ready);
endinterface

### design/crsf_parse.sv
// Input byte register and frame state machine with running CRC.
`include "assert_macros.svh"

module crsf_parse import crsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	crsf_byte_if.sink rx,
	input  logic  slot_free,
	output logic  push,
	output res_t  push_item
);

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_LENGTH = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_DEST   = 3'd3;
	localparam logic [2:0] PH_SOURCE = 3'd4;
	localparam logic [2:0] PH_BODY   = 3'd5;
	localparam logic [2:0] PH_CRC    = 3'd6;

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [2:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] lead_q, length_q, type_q, dest_q, source_q;
	logic [BYTE_W-1:0] count_q, crc_q;
	logic              ext_q;

	logic              emits, advance, is_ext;
	logic [BYTE_W-1:0] hdr, total, count_inc, crc_next;

	assign emits   = (phase_q == PH_BODY) || (phase_q == PH_CRC);
	assign advance = vld_s1 && (slot_free || !emits);
	assign rx.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign is_ext    = (byte_s1 >= cfg.ext_type_start);
	assign hdr       = ext_q ? 8'd4 : 8'd2;
	assign total     = (length_q < hdr) ? '0 : length_q - hdr;
	assign count_inc = count_q + 8'd1;
	assign crc_next  = crc8_step((phase_q == PH_TYPE) ? '0 : crc_q, byte_s1);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_LEAD:   phase_d = PH_LENGTH;
			PH_LENGTH: phase_d = (byte_s1 < 8'd2) ? PH_LEAD : PH_TYPE;
			PH_TYPE: begin
				if (is_ext) begin
					phase_d = (length_q < 8'd4) ? PH_LEAD : PH_DEST;
				end else begin
					phase_d = (length_q == 8'd2) ? PH_CRC : PH_BODY;
				end
			end
			PH_DEST:   phase_d = PH_SOURCE;
			PH_SOURCE: phase_d = (total == '0) ? PH_CRC : PH_BODY;
			PH_BODY:   phase_d = (count_inc >= total) ? PH_CRC : PH_BODY;
			PH_CRC:    phase_d = PH_LEAD;
			default:   phase_d = PH_LEAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (phase_q)
				PH_LEAD: begin
					lead_q  <= byte_s1;
					count_q <= '0;
				end
				PH_LENGTH: length_q <= byte_s1;
				PH_TYPE: begin
					type_q <= byte_s1;
					ext_q  <= is_ext;
					crc_q  <= crc_next;
				end
				PH_DEST: begin
					dest_q <= byte_s1;
					crc_q  <= crc_next;
				end
				PH_SOURCE: begin
					source_q <= byte_s1;
					crc_q    <= crc_next;
				end
				PH_BODY: begin
					crc_q   <= crc_next;
					count_q <= count_inc;
				end
				default: ;
			endcase
		end
	end

	assign push = advance && emits;

	always_comb begin
		push_item.kind           = (phase_q == PH_CRC) ? KIND_END : KIND_PAYLOAD;
		push_item.data_byte      = (phase_q == PH_CRC) ? '0 : byte_s1;
		push_item.byte_offset    = count_q;
		push_item.frame_kind     = type_q;
		push_item.lead_address   = lead_q;
		push_item.dest_address   = ext_q ? dest_q : '0;
		push_item.source_address = ext_q ? source_q : '0;
		push_item.crc_match      = (phase_q == PH_CRC) && (crc_q == byte_s1);
		push_item.readable       = (phase_q == PH_CRC) && (lead_q != cfg.own_address)
			&& (type_q != cfg.dropped_type) && (length_q != 8'd255);
		push_item.last           = (phase_q == PH_CRC);
	end

	`CRSF_ASSERT_NEXT(a_trailer_resyncs, advance && phase_q == PH_CRC,
		phase_q == PH_LEAD, "trailer did not return to lead phase")
	`CRSF_ASSERT(a_offset_in_frame, push && push_item.kind == KIND_PAYLOAD,
		push_item.byte_offset < length_q, "payload offset past frame length")

endmodule

### design/crsf_result_reg.sv
// Output register holding one result item until the sink takes it.
`include "assert_macros.svh"

module crsf_result_reg import crsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  push_item,
	output logic  slot_free,
	crsf_result_if.source res
);

	logic vld_q;
	res_t item_q;

	assign slot_free = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q <= push_item;
		end
	end

	assign res.valid          = vld_q;
	assign res.kind           = item_q.kind;
	assign res.data_byte      = item_q.data_byte;
	assign res.byte_offset    = item_q.byte_offset;
	assign res.frame_kind     = item_q.frame_kind;
	assign res.lead_address   = item_q.lead_address;
	assign res.dest_address   = item_q.dest_address;
	assign res.source_address = item_q.source_address;
	assign res.crc_match      = item_q.crc_match;
	assign res.readable       = item_q.readable;
	assign res.last           = item_q.last;

	`CRSF_ASSERT(a_no_overwrite, push, slot_free, "result overwritten before taken")

endmodule

### design/crsf_frame_receiver.sv
// Top level of the CRSF frame receiver: config registers and the two stages.
//
// Channels: rx takes one received link byte per item; res gives one result
// item per payload byte (kind 0, with its offset) and one end-of-frame report
// per trailer (kind 1, last 1, CRC match and readable flags, payload count).
// Header bytes and aborted frames give no result.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 own address,
// 1 dropped type, 2 extended type start); write only while idle.
// Flow: a byte accepted from rx goes into the input register; the frame state
// machine handles it from there and puts any result it gives into the result
// register, from which res shows it as valid.
// Throughput: one byte per cycle while res is not held, set by the byte-wide
// state machine and its single CRC-8 step between input and result registers.
// Stall: while res is held, bytes that give no result still move through;
// the first one that gives a result waits in the input register and rx
// stays low until the sink takes the pending result.
// Reset: arst_n clears both stages, returns to waiting for a lead byte and
// loads the register defaults 238, 22 and 40.
module crsf_frame_receiver import crsf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	crsf_byte_if.sink            rx,
	crsf_result_if.source        res
);

	cfg_t cfg_q;
	logic slot_free;
	logic push;
	res_t push_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address    <= OWN_ADDRESS_RST;
			cfg_q.dropped_type   <= DROPPED_TYPE_RST;
			cfg_q.ext_type_start <= EXT_TYPE_START_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_ADDRESS:    cfg_q.own_address    <= cfg_wdata;
				CFG_DROPPED_TYPE:   cfg_q.dropped_type   <= cfg_wdata;
				CFG_EXT_TYPE_START: cfg_q.ext_type_start <= cfg_wdata;
				default: ;
			endcase
		end
	end

	crsf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rx        (rx),
		.slot_free (slot_free),
		.push      (push),
		.push_item (push_item)
	);

	crsf_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.slot_free (slot_free),
		.res       (res)
	);

endmodule

### bench/tb_crsf_frame_receiver.sv
// Testbench for crsf_frame_receiver: queued byte stimulus, deframer prediction, result check.
module tb_crsf_frame_receiver import crsf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		WAIT_LEAD, WAIT_LENGTH, WAIT_TYPE, WAIT_DEST, WAIT_SOURCE, IN_BODY, WAIT_CRC
	} frame_phase_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_wdata;

	crsf_byte_if rx_ch();
	crsf_result_if res_ch();

	crsf_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx(rx_ch),
		.res(res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0] stim_q[$];
	res_t pending_results[$];
	res_t oldest;
	cfg_t cfg_model;
	int idle_pct = 27;
	int queued_bytes = 0;
	int errors = 0;
	int payload_seen = 0;
	int reports_seen = 0;
	int crc_bad_seen = 0;
	int readable_seen = 0;
	logic rx_took;

	// deframer state
	frame_phase_e fr_phase;
	logic [7:0] fr_lead, fr_len, fr_type, fr_dest, fr_src, fr_count, fr_crc;
	logic fr_ext;

	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] r;
		r = acc ^ d;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	function automatic logic [7:0] body_size();
		logic [7:0] hdr;
		hdr = fr_ext ? 8'd4 : 8'd2;
		if (fr_len < hdr)
			return 8'd0;
		return fr_len - hdr;
	endfunction

	task automatic emit_result(input logic k, input logic [7:0] d, input logic [7:0] off,
			input logic match, input logic rd);
		res_t r;
		r.kind = k;
		r.data_byte = d;
		r.byte_offset = off;
		r.frame_kind = fr_type;
		r.lead_address = fr_lead;
		r.dest_address = fr_ext ? fr_dest : 8'd0;
		r.source_address = fr_ext ? fr_src : 8'd0;
		r.crc_match = match;
		r.readable = rd;
		r.last = k;
		pending_results.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic rd;
		case (fr_phase)
			WAIT_LEAD: begin
				fr_lead = b;
				fr_len = '0;
				fr_type = '0;
				fr_dest = '0;
				fr_src = '0;
				fr_count = '0;
				fr_crc = '0;
				fr_ext = 1'b0;
				fr_phase = WAIT_LENGTH;
			end
			WAIT_LENGTH: begin
				fr_len = b;
				fr_phase = (b < 8'd2) ? WAIT_LEAD : WAIT_TYPE;
			end
			WAIT_TYPE: begin
				fr_type = b;
				fr_crc = crc8_next(8'd0, b);
				fr_ext = (b >= cfg_model.ext_type_start);
				if (fr_ext)
					fr_phase = (fr_len < 8'd4) ? WAIT_LEAD : WAIT_DEST;
				else
					fr_phase = (body_size() == 8'd0) ? WAIT_CRC : IN_BODY;
			end
			WAIT_DEST: begin
				fr_dest = b;
				fr_crc = crc8_next(fr_crc, b);
				fr_phase = WAIT_SOURCE;
			end
			WAIT_SOURCE: begin
				fr_src = b;
				fr_crc = crc8_next(fr_crc, b);
				fr_phase = (body_size() == 8'd0) ? WAIT_CRC : IN_BODY;
			end
			IN_BODY: begin
				fr_crc = crc8_next(fr_crc, b);
				emit_result(KIND_PAYLOAD, b, fr_count, 1'b0, 1'b0);
				fr_count = fr_count + 8'd1;
				if (fr_count >= body_size())
					fr_phase = WAIT_CRC;
			end
			WAIT_CRC: begin
				rd = (fr_lead != cfg_model.own_address) && (fr_type != cfg_model.dropped_type)
					&& (fr_len != 8'd255);
				emit_result(KIND_END, 8'd0, fr_count, fr_crc == b, rd);
				fr_phase = WAIT_LEAD;
			end
			default: fr_phase = WAIT_LEAD;
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= idle_pct);
			if (!rx_ch.valid || rx_took) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= stim_q[0];
					stim_q.delete(0);
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_took <= 1'b0;
			fr_phase = WAIT_LEAD;
			fr_lead = '0;
			fr_len = '0;
			fr_type = '0;
			fr_dest = '0;
			fr_src = '0;
			fr_count = '0;
			fr_crc = '0;
			fr_ext = 1'b0;
		end else begin
			rx_took <= rx_ch.valid && rx_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t ns: result expected none, actual kind %0h data %0h offset %0h",
						$time, res_ch.kind, res_ch.data_byte, res_ch.byte_offset);
				end else begin
					oldest = pending_results[0];
					pending_results.delete(0);
					check_field("kind", 8'(oldest.kind), 8'(res_ch.kind));
					check_field("data_byte", oldest.data_byte, res_ch.data_byte);
					check_field("byte_offset", oldest.byte_offset, res_ch.byte_offset);
					check_field("frame_kind", oldest.frame_kind, res_ch.frame_kind);
					check_field("lead_address", oldest.lead_address, res_ch.lead_address);
					check_field("dest_address", oldest.dest_address, res_ch.dest_address);
					check_field("source_address", oldest.source_address, res_ch.source_address);
					check_field("crc_match", 8'(oldest.crc_match), 8'(res_ch.crc_match));
					check_field("readable", 8'(oldest.readable), 8'(res_ch.readable));
					check_field("last", 8'(oldest.last), 8'(res_ch.last));
					if (oldest.last) begin
						reports_seen++;
						if (!oldest.crc_match)
							crc_bad_seen++;
						if (oldest.readable)
							readable_seen++;
					end else begin
						payload_seen++;
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready)
				deframe_byte(rx_ch.rx_byte);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		stim_q.push_back(b);
		queued_bytes++;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_type();
		logic [7:0] t;
		case ($urandom_range(7))
			0: t = cfg_model.dropped_type;
			1: t = cfg_model.ext_type_start;
			2: t = cfg_model.ext_type_start - 8'd1;
			3: t = 8'h00;
			4: t = 8'hFF;
			default: t = 8'($urandom);
		endcase
		return t;
	endfunction

	// big: longest payload the length byte allows
	task automatic push_frame(input logic [7:0] lead, input logic [7:0] ftype, input int n,
			input bit big, input bit corrupt);
		logic [7:0] crc, b;
		bit ext;
		int hdr, len;
		ext = (ftype >= cfg_model.ext_type_start);
		hdr = ext ? 4 : 2;
		if (big)
			n = 255 - hdr;
		len = n + hdr;
		queue_byte(lead);
		queue_byte(len[7:0]);
		queue_byte(ftype);
		crc = crc8_next(8'h00, ftype);
		if (ext) begin
			repeat (2) begin
				b = pick_byte();
				queue_byte(b);
				crc = crc8_next(crc, b);
			end
		end
		repeat (n) begin
			b = pick_byte();
			queue_byte(b);
			crc = crc8_next(crc, b);
		end
		if (corrupt)
			crc = crc ^ 8'($urandom_range(255, 1));
		queue_byte(crc);
	endtask

	task automatic random_traffic(input int budget);
		int start, r;
		logic [7:0] lead;
		start = queued_bytes;
		push_frame(pick_byte(), 8'($urandom), 0, 1'b1, 1'b0);
		while (queued_bytes - start < budget) begin
			r = $urandom_range(99);
			if (r < 74) begin
				lead = ($urandom_range(99) < 15) ? cfg_model.own_address : pick_byte();
				push_frame(lead, pick_type(), $urandom_range(10), $urandom_range(99) < 2,
					$urandom_range(99) < 15);
			end else if (r < 84) begin
				queue_byte(pick_byte());
				queue_byte(8'($urandom_range(1)));
			end else if (r < 94) begin
				queue_byte(pick_byte());
				queue_byte(8'($urandom_range(3, 2)));
				queue_byte(8'($urandom_range(255, cfg_model.ext_type_start)));
			end else begin
				repeat ($urandom_range(4, 1)) queue_byte(8'($urandom));
			end
		end
	endtask

	task automatic drain();
		while (stim_q.size() != 0 || rx_ch.valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_OWN_ADDRESS: cfg_model.own_address = val;
			CFG_DROPPED_TYPE: cfg_model.dropped_type = val;
			CFG_EXT_TYPE_START: cfg_model.ext_type_start = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cfg_model.own_address = OWN_ADDRESS_RST;
		cfg_model.dropped_type = DROPPED_TYPE_RST;
		cfg_model.ext_type_start = EXT_TYPE_START_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty payload, short lengths, extended boundary, own address, dropped type
		push_frame(8'hC8, 8'h00, 0, 1'b0, 1'b0);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h01);
		queue_byte(8'hC8);
		queue_byte(8'h03);
		queue_byte(8'hFF);
		push_frame(8'hC8, EXT_TYPE_START_RST, 0, 1'b0, 1'b0);
		push_frame(OWN_ADDRESS_RST, EXT_TYPE_START_RST - 8'd1, 2, 1'b0, 1'b1);
		push_frame(8'hFF, DROPPED_TYPE_RST, 1, 1'b0, 1'b0);
		drain();
		random_traffic(330);
		drain();

		write_reg(CFG_OWN_ADDRESS, 8'h00);
		write_reg(CFG_DROPPED_TYPE, 8'hFF);
		write_reg(CFG_EXT_TYPE_START, 8'h00);
		random_traffic(330);
		drain();

		write_reg(CFG_OWN_ADDRESS, 8'hFF);
		write_reg(CFG_DROPPED_TYPE, 8'h00);
		write_reg(CFG_EXT_TYPE_START, 8'hFF);
		random_traffic(330);
		drain();

		write_reg(CFG_UNUSED, 8'($urandom));
		write_reg(CFG_OWN_ADDRESS, 8'($urandom));
		write_reg(CFG_DROPPED_TYPE, 8'($urandom));
		write_reg(CFG_EXT_TYPE_START, 8'($urandom_range(254, 1)));
		idle_pct = 0;
		random_traffic(330);
		drain();
		idle_pct = 27;

		write_reg(CFG_OWN_ADDRESS, OWN_ADDRESS_RST);
		write_reg(CFG_DROPPED_TYPE, DROPPED_TYPE_RST);
		write_reg(CFG_EXT_TYPE_START, EXT_TYPE_START_RST);
		random_traffic(330);
		drain();

		$display("Sent %0d link bytes over five register settings, one with no idling.",
			queued_bytes);
		$display("Checked %0d payload items and %0d end reports (%0d bad CRC, %0d readable).",
			payload_seen, reports_seen, crc_bad_seen, readable_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_crsf_frame_receiver: done, clean");
		end else begin
			$display("tb_crsf_frame_receiver: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_crsf_frame_receiver: done, errors");
		$finish;
	end

endmodule
